// File: hw/rtl/polyphase_stereo_resampler_core_assert.svh
// ---------------------------------------------------------------------------
// Resampler assertion macros
// Clocked implication checks for the core file, which includes them.
// ---------------------------------------------------------------------------
`ifndef POLYPHASE_STEREO_RESAMPLER_CORE_ASSERT_SVH
`define POLYPHASE_STEREO_RESAMPLER_CORE_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define PSR_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define PSR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: hw/rtl/psr_pkg.sv
// ---------------------------------------------------------------------------
// Resampler package
// Payload types, command and register codes, and default sizes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package psr_pkg;

    localparam int TAPS_DEF           = 64;
    localparam int MAX_PHASE_BITS_DEF = 5;
    localparam int INTERP_WIDTH_DEF   = 12;
    localparam int BUFFER_FRAMES_DEF  = 4096;

    typedef enum logic [1:0] {
        CMD_LOAD_COEF = 2'd0,
        CMD_STORE_FRAME = 2'd1,
        CMD_COMPUTE = 2'd2,
        CMD_SET_POS = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        REG_STEP = 2'd0,
        REG_PHASE_BITS = 2'd1,
        REG_LCG_MULT = 2'd2,
        REG_LCG_ADD = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [1:0]          cmd;
        logic [11:0]         address;
        logic signed [23:0]  coefficient;
        logic signed [15:0]  left_in;
        logic signed [15:0]  right_in;
        logic signed [63:0]  position_value;
        logic [31:0]         dither_seed;
        logic [12:0]         in_length;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] left_out;
        logic signed [15:0] right_out;
    } out_item_t;

    // Tap request from the sequencer to the datapath.
    typedef struct packed {
        logic valid;
        logic in_range;
        logic first;
        logic last;
    } tap_ctl_t;

endpackage

// File: hw/rtl/psr_mac.sv
// ---------------------------------------------------------------------------
// Resampler tap datapath
// Blends two coefficients, multiplies by both channels and accumulates.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module psr_mac
    import psr_pkg::*;
#(
    parameter int INTERP_WIDTH = INTERP_WIDTH_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  tap_ctl_t                ctl,
    input  logic signed [23:0]      c0,
    input  logic signed [23:0]      c1,
    input  logic [31:0]             frame,
    input  logic [INTERP_WIDTH-1:0] w1,
    output logic                    done,
    output logic signed [55:0]      acc_l,
    output logic signed [55:0]      acc_r
);

    localparam int BW = 24 + INTERP_WIDTH + 2;

    tap_ctl_t ctl_reg;
    logic signed [BW-1:0] prod0_reg, prod1_reg;
    logic [31:0] frame_reg;
    tap_ctl_t ctl2_reg;
    logic signed [25:0] blend_reg;
    logic [31:0] frame2_reg;
    tap_ctl_t ctl3_reg;
    logic signed [41:0] pl_reg, pr_reg;
    logic signed [55:0] acc_l_reg, acc_r_reg;
    logic done_reg;

    logic signed [INTERP_WIDTH+1:0] w0_s, w1_s;
    logic signed [BW-1:0] bsum;

    assign w1_s = $signed({2'b00, w1});
    assign w0_s = $signed((INTERP_WIDTH+2)'(1) <<< INTERP_WIDTH) - w1_s;
    assign bsum = prod0_reg + prod1_reg + $signed(BW'(1) << (INTERP_WIDTH - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg  <= '0;
            ctl2_reg <= '0;
            ctl3_reg <= '0;
            done_reg <= 1'b0;
            acc_l_reg <= '0;
            acc_r_reg <= '0;
        end
        else
        begin
            ctl_reg  <= ctl;
            ctl2_reg <= ctl_reg;
            ctl3_reg <= ctl2_reg;
            done_reg <= ctl3_reg.valid && ctl3_reg.last;
            if (ctl3_reg.valid)
            begin
                acc_l_reg <= (ctl3_reg.first ? 56'sd0 : acc_l_reg)
                    + (ctl3_reg.in_range ? 56'(pl_reg) : 56'sd0);
                acc_r_reg <= (ctl3_reg.first ? 56'sd0 : acc_r_reg)
                    + (ctl3_reg.in_range ? 56'(pr_reg) : 56'sd0);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod0_reg  <= BW'(c0 * w0_s);
        prod1_reg  <= BW'(c1 * w1_s);
        frame_reg  <= frame;
        blend_reg  <= 26'(bsum >>> INTERP_WIDTH);
        frame2_reg <= frame_reg;
        pl_reg     <= 42'($signed(frame2_reg[15:0]) * blend_reg);
        pr_reg     <= 42'($signed(frame2_reg[31:16]) * blend_reg);
    end

    assign done  = done_reg;
    assign acc_l = acc_l_reg;
    assign acc_r = acc_r_reg;

endmodule

// File: hw/rtl/psr_post.sv
// ---------------------------------------------------------------------------
// Resampler output stage
// Rounds both sums, adds dither, steps the generator and saturates.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module psr_post
    import psr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [55:0] acc_l,
    input  logic signed [55:0] acc_r,
    input  logic [31:0]        dither_in,
    input  logic [31:0]        lcg_mult,
    input  logic [31:0]        lcg_add,
    output logic               done,
    output out_item_t          result,
    output logic [31:0]        dither_out
);

    typedef enum logic [3:0] {
        P_IDLE = 4'b0001,
        P_MUL1 = 4'b0010,
        P_MUL2 = 4'b0100,
        P_DONE = 4'b1000
    } pstate_t;

    pstate_t state_reg, state_next;
    logic [31:0] d_reg, d_next;
    logic signed [49:0] zl_reg, zr_reg;
    logic signed [15:0] ol_reg, or_reg;

    logic signed [49:0] zl_d, zr_d;
    logic [31:0] lcg_val;

    function automatic logic signed [15:0] sat16(input logic signed [49:0] v);
        logic signed [34:0] s;
        begin
            s = 35'(v >>> 15);
            if (s > 35'sd32767)
                sat16 = 16'sh7fff;
            else if (s < -35'sd32768)
                sat16 = -16'sh8000;
            else
                sat16 = 16'(s);
        end
    endfunction

    assign lcg_val = d_reg * lcg_mult + lcg_add;
    assign zl_d = zl_reg + $signed({35'd0, d_reg[31:17]});
    assign zr_d = zr_reg + $signed({35'd0, d_reg[31:17]});

    always_comb
    begin
        state_next = state_reg;
        d_next = d_reg;
        case (state_reg)
            P_IDLE: if (start) begin state_next = P_MUL1; d_next = dither_in; end
            P_MUL1: begin state_next = P_MUL2; d_next = lcg_val; end
            P_MUL2: begin state_next = P_DONE; d_next = lcg_val; end
            P_DONE: state_next = P_IDLE;
            default: state_next = P_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= P_IDLE;
            d_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            d_reg <= d_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == P_IDLE && start)
        begin
            zl_reg <= 50'((acc_l + 56'sd64) >>> 7);
            zr_reg <= 50'((acc_r + 56'sd64) >>> 7);
        end
        if (state_reg == P_MUL1)
            ol_reg <= sat16(zl_d);
        if (state_reg == P_MUL2)
            or_reg <= sat16(zr_d);
    end

    assign done = (state_reg == P_DONE);
    assign result.left_out = ol_reg;
    assign result.right_out = or_reg;
    assign dither_out = d_reg;

endmodule

// File: hw/rtl/polyphase_stereo_resampler_core.sv
// A compute transfer runs the tap loop, the tap datapath and the output stage before its
// result is registered; store, load and set transfers are taken while the core is idle.
// No transfer is accepted until a computed frame has been taken, and the single tap
// loop reads the coefficient and frame memories once per tap.
// Reset sets the control registers to defaults; the memories hold nothing until loaded.
`timescale 1ns / 1ps

`include "polyphase_stereo_resampler_core_assert.svh"

// ---------------------------------------------------------------------------
// Polyphase stereo resampler core
// Command interpreter, memories, tap sequencer and output register.
// ---------------------------------------------------------------------------
module polyphase_stereo_resampler_core
    import psr_pkg::*;
#(
    parameter int TAPS           = TAPS_DEF,
    parameter int MAX_PHASE_BITS = MAX_PHASE_BITS_DEF,
    parameter int INTERP_WIDTH   = INTERP_WIDTH_DEF,
    parameter int BUFFER_FRAMES  = BUFFER_FRAMES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    localparam int COEF_DEPTH = ((1 << MAX_PHASE_BITS) + 1) * TAPS;
    localparam int CAW = $clog2(COEF_DEPTH);
    localparam int FAW = $clog2(BUFFER_FRAMES);
    localparam int TW  = $clog2(TAPS);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RUN  = 4'b0010,
        S_POST = 4'b0100,
        S_OUT  = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic [35:0] step_reg;
    logic [2:0]  pbits_reg;
    logic [31:0] lcg_mult_reg, lcg_add_reg;
    logic [63:0] pos_reg;
    logic [31:0] dither_reg;
    logic [TW:0] tap_reg;
    logic [CAW-1:0] base0_reg, base1_reg;
    logic signed [33:0] first_reg;
    logic [12:0] len_reg;
    logic [INTERP_WIDTH-1:0] w1_reg;
    logic out_valid_reg;
    out_item_t out_reg;

    logic signed [23:0] coef_mem0 [COEF_DEPTH];
    logic signed [23:0] coef_mem1 [COEF_DEPTH];
    logic [31:0] frame_mem [BUFFER_FRAMES];
    logic signed [23:0] c0_rd, c1_rd;
    logic [31:0] fr_rd;

    tap_ctl_t tap_ctl;
    logic mac_done, post_done;
    logic signed [55:0] acc_l, acc_r;
    out_item_t post_res;
    logic [31:0] post_dither;

    logic in_xfer, out_xfer;
    logic signed [33:0] k_idx;
    logic [2:0] pb;
    logic [31:0] frac;
    logic [31:0] fn;
    logic [47:0] frac_ext;
    logic [12:0] len_c;

    assign in_xfer = in_valid && in_ready;
    assign out_xfer = out_valid_reg && out_ready;
    assign in_ready = (state_reg == S_IDLE) && !out_valid_reg;
    assign cfg_ready = 1'b1;

    assign pb = (pbits_reg > 3'(MAX_PHASE_BITS)) ? 3'(MAX_PHASE_BITS) : pbits_reg;
    assign frac = pos_reg[31:0];
    assign fn = (pb == 3'd0) ? 32'd0 : (frac >> (6'd32 - {3'd0, pb}));
    assign frac_ext = {frac, 16'd0} << pb;
    assign len_c = (in_data.in_length > 13'(BUFFER_FRAMES))
        ? 13'(BUFFER_FRAMES) : in_data.in_length;
    assign k_idx = first_reg + 34'($unsigned(tap_reg));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (in_xfer && in_data.cmd == CMD_COMPUTE)
                    state_next = S_RUN;
            S_RUN:
                if (tap_reg == (TW+1)'(TAPS - 1))
                    state_next = S_POST;
            S_POST:
                if (post_done)
                    state_next = S_OUT;
            S_OUT:
                state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg <= 36'h1_0000_0000;
            pbits_reg <= 3'd5;
            lcg_mult_reg <= 32'd1664525;
            lcg_add_reg <= 32'd1013904223;
            pos_reg <= '0;
            dither_reg <= '0;
            tap_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                case (reg_idx_t'(cfg_index))
                    REG_STEP:       step_reg <= cfg_data[35:0];
                    REG_PHASE_BITS: pbits_reg <= cfg_data[2:0];
                    REG_LCG_MULT:   lcg_mult_reg <= cfg_data[31:0];
                    REG_LCG_ADD:    lcg_add_reg <= cfg_data[31:0];
                    default:        ;
                endcase
            end
            if (in_xfer && in_data.cmd == CMD_SET_POS)
            begin
                pos_reg <= in_data.position_value;
                dither_reg <= in_data.dither_seed;
            end
            if (state_reg == S_RUN)
                tap_reg <= tap_reg + 1'b1;
            else
                tap_reg <= '0;
            if (state_reg == S_OUT)
            begin
                pos_reg <= pos_reg + 64'(step_reg);
                dither_reg <= post_dither;
                out_valid_reg <= 1'b1;
            end
            else if (out_xfer)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer && in_data.cmd == CMD_COMPUTE)
        begin
            base0_reg <= CAW'(fn * TAPS);
            base1_reg <= CAW'((fn + 32'd1) * TAPS);
            first_reg <= $signed({pos_reg[63], pos_reg[63], pos_reg[63:32]})
                - $signed(34'(TAPS / 2));
            len_reg <= len_c;
            w1_reg <= frac_ext[47 -: INTERP_WIDTH];
        end
        if (state_reg == S_OUT)
            out_reg <= post_res;
    end

    // Both coefficient banks hold the same table, so phases p and p+1 are read together.
    always_ff @(posedge clk)
    begin
        if (in_xfer && in_data.cmd == CMD_LOAD_COEF && 32'(in_data.address) < COEF_DEPTH)
        begin
            coef_mem0[CAW'(in_data.address)] <= in_data.coefficient;
            coef_mem1[CAW'(in_data.address)] <= in_data.coefficient;
        end
        c0_rd <= coef_mem0[base0_reg + CAW'(tap_reg[TW-1:0])];
        c1_rd <= coef_mem1[base1_reg + CAW'(tap_reg[TW-1:0])];
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer && in_data.cmd == CMD_STORE_FRAME && 32'(in_data.address) < BUFFER_FRAMES)
            frame_mem[FAW'(in_data.address)] <= {in_data.right_in, in_data.left_in};
        fr_rd <= frame_mem[FAW'(k_idx)];
    end

    tap_ctl_t tap_now;
    always_comb
    begin
        tap_now.valid = (state_reg == S_RUN);
        tap_now.in_range = (k_idx >= 0) && (k_idx < $signed({21'd0, len_reg}));
        tap_now.first = (tap_reg == '0);
        tap_now.last = (tap_reg == (TW+1)'(TAPS - 1));
    end

    // Align control with the registered memory read.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tap_ctl <= '0;
        else
            tap_ctl <= tap_now;
    end

    psr_mac #(.INTERP_WIDTH(INTERP_WIDTH)) u_mac (
        .clk(clk), .rst_n(rst_n), .ctl(tap_ctl),
        .c0(c0_rd), .c1(c1_rd), .frame(fr_rd), .w1(w1_reg),
        .done(mac_done), .acc_l(acc_l), .acc_r(acc_r)
    );

    psr_post u_post (
        .clk(clk), .rst_n(rst_n), .start(mac_done),
        .acc_l(acc_l), .acc_r(acc_r), .dither_in(dither_reg),
        .lcg_mult(lcg_mult_reg), .lcg_add(lcg_add_reg),
        .done(post_done), .result(post_res), .dither_out(post_dither)
    );

    assign out_valid = out_valid_reg;
    assign out_data = out_reg;

    `PSR_ASSERT_IMPL(a_no_accept_busy, state_reg != S_IDLE, !in_ready)
    `PSR_ASSERT_NEXT(a_out_follows, state_reg == S_OUT, out_valid_reg)
    `PSR_ASSERT_IMPL(a_done_in_post, post_done, state_reg == S_POST)

endmodule
